[src/asbg_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the sample budget governor.
// No dependencies; the files that use it refer to it by scoped names.
package asbg_pkg;

  // Fixed field widths
  localparam int DUR_W    = 32;
  localparam int SMP_W    = 16;
  localparam int COUNT_W  = 16;
  localparam int WLEN_W   = 5;
  localparam int TGT_W    = 32;
  localparam int MRG_W    = 10;
  localparam int BUDGET_W = TGT_W + MRG_W;
  localparam int MISS_W   = 8;

  // APB port geometry
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_DEFAULT_COUNT = 3'd0;
  localparam logic [2:0] REG_MIN_COUNT     = 3'd1;
  localparam logic [2:0] REG_MAX_COUNT     = 3'd2;
  localparam logic [2:0] REG_WINDOW_LENGTH = 3'd3;
  localparam logic [2:0] REG_TARGET_TICKS  = 3'd4;
  localparam logic [2:0] REG_MARGIN_Q8     = 3'd5;

  // Register reset values
  localparam logic [COUNT_W-1:0] RST_DEFAULT_COUNT = 16'd256;
  localparam logic [COUNT_W-1:0] RST_MIN_COUNT     = 16'd16;
  localparam logic [COUNT_W-1:0] RST_MAX_COUNT     = 16'd4096;
  localparam logic [WLEN_W-1:0]  RST_WINDOW_LENGTH = 5'd8;
  localparam logic [TGT_W-1:0]   RST_TARGET_TICKS  = 32'd20000;
  localparam logic [MRG_W-1:0]   RST_MARGIN_Q8     = 10'd256;

  localparam logic [MISS_W-1:0] MISS_MAX      = 8'd255;
  localparam logic [MISS_W-1:0] MISS_FALLBACK = 8'd2;

  typedef struct packed {
    logic [COUNT_W-1:0] default_count;
    logic [COUNT_W-1:0] min_count;
    logic [COUNT_W-1:0] max_count;
    logic [WLEN_W-1:0]  window_length;
    logic [TGT_W-1:0]   target_ticks;
    logic [MRG_W-1:0]   margin_q8;
  } cfg_t;

  // Which division the shared divider runs
  typedef enum logic [1:0] {
    DIV_PER = 2'd0,  // duration * 2^F / samples
    DIV_AVG = 2'd1,  // history sum / history count
    DIV_BUD = 2'd2   // budget * 2^(F-8) / average
  } div_op_e;

  typedef struct packed {
    logic    accept;
    logic    div_start;
    div_op_e div_op;
    logic    evict;
    logic    push;
    logic    set_default;
    logic    clamp;
    logic    finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic guard;
    logic div_busy;
    logic avg_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

[src/asbg_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for report and result transactions.
// Depends on asbg_pkg for field widths.
interface asbg_in_if;
  logic                         valid;
  logic                         ready;
  logic [asbg_pkg::DUR_W-1:0]   duration_ticks;
  logic [asbg_pkg::SMP_W-1:0]   samples_used;

  modport source (output valid, output duration_ticks, output samples_used, input ready);
  modport sink   (input valid, input duration_ticks, input samples_used, output ready);
endinterface

interface asbg_out_if;
  logic                         valid;
  logic                         ready;
  logic [asbg_pkg::COUNT_W-1:0] next_count;
  logic                         used_default;
  logic                         fallback;

  modport source (output valid, output next_count, output used_default, output fallback,
                  input ready);
  modport sink   (input valid, input next_count, input used_default, input fallback,
                  output ready);
endinterface

[src/adaptive_sample_budget_governor_unit.sv]
`timescale 1ns / 1ps
// Adaptive sample budget governor: top level with APB register bank.
// Depends on asbg_pkg, asbg_if, asbg_ctrl and asbg_dp (with asbg_div, asbg_ram).
//
// Usage
//  - req_i carries one report transaction (duration_ticks, samples_used);
//    rsp_o returns exactly one result transaction per report
//    (next_count, used_default, fallback), in order.
//  - Registers are written over APB at byte address 4*index; write them only
//    while no report is in flight. pready is tied high, reads are zero-wait.
//  - A report with zero duration or zero samples takes the guard path:
//    accept leads straight to hand-off; history, sum and miss streak stay.
//  - A valid report runs up to three divisions on one shared bit-serial
//    divider: per-sample time, window average and budget quotient, the
//    last skipped when the average is zero. The divider yields one
//    quotient bit per cycle.
//  - One report is processed at a time. The result sits in an output
//    register, so the next report is accepted while it waits; a stalled
//    receiver holds the block only once the next result is ready.
//  - Reset (async, active low) clears the history count, running sum,
//    ring pointer and miss streak and restores register defaults. The
//    history ring itself needs no clearing: only written entries are read.
module adaptive_sample_budget_governor_unit #(
  parameter int WINDOW_MAX = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  asbg_in_if.sink                       req_i,
  asbg_out_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [asbg_pkg::APB_AW-1:0]   paddr,
  input  logic [asbg_pkg::APB_DW-1:0]   pwdata,
  output logic [asbg_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  asbg_pkg::cfg_t      cfg_q, cfg_d;
  asbg_pkg::ctrl_cmd_t cmd;
  asbg_pkg::ctrl_sts_t sts;
  logic                cfg_wr;
  logic [2:0]          reg_idx;

  // Register bank: written on the access phase of an APB write
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        asbg_pkg::REG_DEFAULT_COUNT: cfg_d.default_count = pwdata[asbg_pkg::COUNT_W-1:0];
        asbg_pkg::REG_MIN_COUNT:     cfg_d.min_count     = pwdata[asbg_pkg::COUNT_W-1:0];
        asbg_pkg::REG_MAX_COUNT:     cfg_d.max_count     = pwdata[asbg_pkg::COUNT_W-1:0];
        asbg_pkg::REG_WINDOW_LENGTH: cfg_d.window_length = pwdata[asbg_pkg::WLEN_W-1:0];
        asbg_pkg::REG_TARGET_TICKS:  cfg_d.target_ticks  = pwdata[asbg_pkg::TGT_W-1:0];
        asbg_pkg::REG_MARGIN_Q8:     cfg_d.margin_q8     = pwdata[asbg_pkg::MRG_W-1:0];
        default: ;  // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      asbg_pkg::REG_DEFAULT_COUNT: prdata = asbg_pkg::APB_DW'(cfg_q.default_count);
      asbg_pkg::REG_MIN_COUNT:     prdata = asbg_pkg::APB_DW'(cfg_q.min_count);
      asbg_pkg::REG_MAX_COUNT:     prdata = asbg_pkg::APB_DW'(cfg_q.max_count);
      asbg_pkg::REG_WINDOW_LENGTH: prdata = asbg_pkg::APB_DW'(cfg_q.window_length);
      asbg_pkg::REG_TARGET_TICKS:  prdata = asbg_pkg::APB_DW'(cfg_q.target_ticks);
      asbg_pkg::REG_MARGIN_Q8:     prdata = asbg_pkg::APB_DW'(cfg_q.margin_q8);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_count <= asbg_pkg::RST_DEFAULT_COUNT;
      cfg_q.min_count     <= asbg_pkg::RST_MIN_COUNT;
      cfg_q.max_count     <= asbg_pkg::RST_MAX_COUNT;
      cfg_q.window_length <= asbg_pkg::RST_WINDOW_LENGTH;
      cfg_q.target_ticks  <= asbg_pkg::RST_TARGET_TICKS;
      cfg_q.margin_q8     <= asbg_pkg::RST_MARGIN_Q8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sequencer
  asbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // History, divider, clamp and result register
  asbg_dp #(
    .WINDOW_MAX (WINDOW_MAX),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .duration_ticks_i (req_i.duration_ticks),
    .samples_used_i   (req_i.samples_used),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .next_count_o     (rsp_o.next_count),
    .used_default_o   (rsp_o.used_default),
    .fallback_o       (rsp_o.fallback)
  );

endmodule

[src/asbg_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module asbg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/asbg_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, dividend left-aligned.
// No dependencies.
module asbg_div #(
  parameter int DVD_W  = 52,
  parameter int DSR_W  = 48,
  parameter int ITER_W = $clog2(DVD_W + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [DSR_W-1:0]   divisor_i,
  input  logic [ITER_W-1:0]  iters_i,
  output logic               busy_o,
  output logic [DVD_W-1:0]   quotient_o
);

  logic              busy_q, busy_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [DVD_W-1:0]  acc_q, acc_d;
  logic [DSR_W-1:0]  rem_q, rem_d;
  logic [DSR_W-1:0]  dsr_q, dsr_d;
  logic [DSR_W:0]    rem_sh;
  logic              q_bit;

  always_comb begin
    busy_d = busy_q;
    iter_d = iter_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q, acc_q[DVD_W-1]};
    q_bit  = (rem_sh >= {1'b0, dsr_q});
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = iters_i;
      acc_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = q_bit ? DSR_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DSR_W-1:0];
      acc_d  = {acc_q[DVD_W-2:0], q_bit};
      iter_d = iter_q - 1'b1;
      busy_d = (iter_q != ITER_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = acc_q;

endmodule

[src/asbg_dp.sv]
`timescale 1ns / 1ps
// Datapath: history ring and sum, miss streak, shared divider, clamp, result register.
// Depends on asbg_pkg, asbg_ram and asbg_div.
module asbg_dp #(
  parameter int WINDOW_MAX = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  asbg_pkg::cfg_t                cfg_i,
  input  logic [asbg_pkg::DUR_W-1:0]    duration_ticks_i,
  input  logic [asbg_pkg::SMP_W-1:0]    samples_used_i,
  input  asbg_pkg::ctrl_cmd_t           cmd_i,
  output asbg_pkg::ctrl_sts_t           sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [asbg_pkg::COUNT_W-1:0]  next_count_o,
  output logic                          used_default_o,
  output logic                          fallback_o
);
  localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W = CNT_W + 1;
  localparam int PER_W  = asbg_pkg::DUR_W + FRAC_BITS;
  localparam int SUM_W  = PER_W + $clog2(WINDOW_MAX);
  localparam int BUD_W  = asbg_pkg::BUDGET_W + FRAC_BITS - 8;
  localparam int DVD_W  = (SUM_W > BUD_W) ? SUM_W : BUD_W;
  localparam int DSR_W  = PER_W;
  localparam int ITER_W = $clog2(DVD_W + 1);

  logic [asbg_pkg::DUR_W-1:0]    dur_q;
  logic [asbg_pkg::SMP_W-1:0]    smp_q;
  logic [CNT_W-1:0]              hcnt_q;
  logic [IDX_W-1:0]              oldest_q;
  logic [SUM_W-1:0]              sum_q;
  logic [asbg_pkg::MISS_W-1:0]   miss_q;
  logic [asbg_pkg::BUDGET_W-1:0] budget_q;
  logic [asbg_pkg::COUNT_W-1:0]  res_q;
  logic                          dflt_q;
  logic                          out_valid_q;
  logic [asbg_pkg::COUNT_W-1:0]  out_count_q;
  logic                          out_dflt_q;
  logic                          out_fb_q;

  logic                          guard;
  logic [31:0]                   wlen_ext;
  logic [CNT_W-1:0]              win;
  logic                          evict_hit;
  logic [IDX_W-1:0]              oldest_nxt;
  logic [SLOT_W-1:0]             slot_sum;
  logic [IDX_W-1:0]              slot;
  logic [PER_W-1:0]              ram_rdata;
  logic [PER_W-1:0]              per;

  logic [DVD_W-1:0]              div_dvd;
  logic [DSR_W-1:0]              div_dsr;
  logic [ITER_W-1:0]             div_iters;
  logic                          div_busy;
  logic [DVD_W-1:0]              quo;

  logic [DVD_W-1:0]              min_ext;
  logic [DVD_W-1:0]              max_ext;
  logic [DVD_W-1:0]              lo_sel;
  logic [asbg_pkg::COUNT_W-1:0]  clamped;

  assign guard = (duration_ticks_i == '0) || (samples_used_i == '0);

  // Effective window: zero acts as one, oversize acts as WINDOW_MAX
  always_comb begin
    wlen_ext = 32'(cfg_i.window_length);
    if (wlen_ext == 32'd0) begin
      win = CNT_W'(1);
    end else if (wlen_ext > 32'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = CNT_W'(wlen_ext);
    end
  end

  assign evict_hit  = (hcnt_q >= win);
  assign oldest_nxt = (32'(oldest_q) == WINDOW_MAX - 1) ? '0 : oldest_q + 1'b1;

  always_comb begin
    slot_sum = SLOT_W'(oldest_q) + SLOT_W'(hcnt_q);
    if (slot_sum >= SLOT_W'(WINDOW_MAX)) begin
      slot_sum = slot_sum - SLOT_W'(WINDOW_MAX);
    end
    slot = IDX_W'(slot_sum);
  end

  assign per = PER_W'(quo);

  asbg_ram #(
    .WIDTH (PER_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (slot),
    .wdata_i (per),
    .raddr_i (oldest_q),
    .rdata_o (ram_rdata)
  );

  // Operand selection for the shared divider
  always_comb begin
    case (cmd_i.div_op)
      asbg_pkg::DIV_AVG: begin
        div_dvd   = DVD_W'(sum_q) << (DVD_W - SUM_W);
        div_dsr   = DSR_W'(hcnt_q);
        div_iters = ITER_W'(SUM_W);
      end
      asbg_pkg::DIV_BUD: begin
        div_dvd   = DVD_W'(budget_q) << (DVD_W - asbg_pkg::BUDGET_W);
        div_dsr   = DSR_W'(quo);
        div_iters = ITER_W'(BUD_W);
      end
      default: begin
        div_dvd   = DVD_W'({dur_q, {FRAC_BITS{1'b0}}}) << (DVD_W - PER_W);
        div_dsr   = DSR_W'(smp_q);
        div_iters = ITER_W'(PER_W);
      end
    endcase
  end

  asbg_div #(
    .DVD_W (DVD_W),
    .DSR_W (DSR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .iters_i    (div_iters),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // Clamp: lower bound first, upper bound last
  always_comb begin
    min_ext = DVD_W'(cfg_i.min_count);
    max_ext = DVD_W'(cfg_i.max_count);
    lo_sel  = (quo < min_ext) ? min_ext : quo;
    clamped = (lo_sel > max_ext) ? cfg_i.max_count : asbg_pkg::COUNT_W'(lo_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q      <= '0;
      oldest_q    <= '0;
      sum_q       <= '0;
      miss_q      <= '0;
      dflt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        dflt_q <= guard;
        if (!guard) begin
          if (duration_ticks_i > cfg_i.target_ticks) begin
            if (miss_q != asbg_pkg::MISS_MAX) begin
              miss_q <= miss_q + 1'b1;
            end
          end else begin
            miss_q <= '0;
          end
        end
      end
      if (cmd_i.evict && evict_hit) begin
        sum_q    <= sum_q - SUM_W'(ram_rdata);
        oldest_q <= oldest_nxt;
        hcnt_q   <= hcnt_q - 1'b1;
      end
      if (cmd_i.push) begin
        sum_q  <= sum_q + SUM_W'(per);
        hcnt_q <= hcnt_q + 1'b1;
      end
      if (cmd_i.set_default) begin
        dflt_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dur_q <= duration_ticks_i;
      smp_q <= samples_used_i;
    end
    if (cmd_i.push) begin
      budget_q <= asbg_pkg::BUDGET_W'(cfg_i.target_ticks) *
                  asbg_pkg::BUDGET_W'(cfg_i.margin_q8);
    end
    if (cmd_i.clamp) begin
      res_q <= clamped;
    end
    if (cmd_i.finish) begin
      out_count_q <= dflt_q ? cfg_i.default_count : res_q;
      out_dflt_q  <= dflt_q;
      out_fb_q    <= (miss_q >= asbg_pkg::MISS_FALLBACK);
    end
  end

  assign sts_o.guard    = guard;
  assign sts_o.div_busy = div_busy;
  assign sts_o.avg_zero = (quo == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign next_count_o   = out_count_q;
  assign used_default_o = out_dflt_q;
  assign fallback_o     = out_fb_q;

endmodule

[src/asbg_ctrl.sv]
`timescale 1ns / 1ps
// Controller: runs accept, up to three divisions, ring update, clamp, hand-off.
// Depends on asbg_pkg.
module asbg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  asbg_pkg::ctrl_sts_t  sts_i,
  output asbg_pkg::ctrl_cmd_t  cmd_o
);
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PER_GO  = 4'd1;
  localparam logic [3:0] S_PER_RUN = 4'd2;
  localparam logic [3:0] S_EVICT   = 4'd3;
  localparam logic [3:0] S_PUSH    = 4'd4;
  localparam logic [3:0] S_AVG_GO  = 4'd5;
  localparam logic [3:0] S_AVG_RUN = 4'd6;
  localparam logic [3:0] S_BUD_GO  = 4'd7;
  localparam logic [3:0] S_BUD_RUN = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.guard ? S_DONE : S_PER_GO;
        end
      end
      S_PER_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = asbg_pkg::DIV_PER;
        state_d         = S_PER_RUN;
      end
      S_PER_RUN: begin
        if (!sts_i.div_busy) begin
          state_d = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d     = S_PUSH;
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_AVG_GO;
      end
      S_AVG_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = asbg_pkg::DIV_AVG;
        state_d         = S_AVG_RUN;
      end
      S_AVG_RUN: begin
        if (!sts_i.div_busy) begin
          if (sts_i.avg_zero) begin
            cmd_o.set_default = 1'b1;
            state_d           = S_DONE;
          end else begin
            state_d = S_BUD_GO;
          end
        end
      end
      S_BUD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = asbg_pkg::DIV_BUD;
        state_d         = S_BUD_RUN;
      end
      S_BUD_RUN: begin
        if (!sts_i.div_busy) begin
          cmd_o.clamp = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

[tb/adaptive_sample_budget_governor_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the sample budget governor: directed table, then random phases.
// Depends on asbg_pkg, asbg_if and the governor RTL; reads no files.
module adaptive_sample_budget_governor_unit_tb;

  localparam int RING_DEPTH  = 16;         // matches WINDOW_MAX of the dut
  localparam int FRAC_SHIFT  = 16;         // matches FRAC_BITS of the dut
  localparam int LONG_HOLD   = 800;        // receiver hold-off, long enough to back up the input
  localparam int SETTLE      = 200;        // a little over one full report latency
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int N_PHASES    = 10;
  localparam int PEND_DEPTH  = 16;         // far above the few reports the block can hold

  typedef struct packed {
    logic [asbg_pkg::COUNT_W-1:0] next_count;
    logic                         used_default;
    logic                         fallback;
  } budget_rsp_t;

  typedef struct {
    logic [asbg_pkg::DUR_W-1:0] dur;
    logic [asbg_pkg::SMP_W-1:0] cnt;
    bit                         typed;   // expectation written in the row rather than predicted
    budget_rsp_t                want;
  } report_row_t;

  logic clk_i;
  logic rst_ni;

  asbg_in_if  req_if ();
  asbg_out_if rsp_if ();

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [asbg_pkg::APB_AW-1:0] paddr;
  logic [asbg_pkg::APB_DW-1:0] pwdata;
  logic [asbg_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  adaptive_sample_budget_governor_unit #(
    .WINDOW_MAX (RING_DEPTH),
    .FRAC_BITS  (FRAC_SHIFT)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the governor: register copy plus history window and miss streak
  // ---------------------------------------------------------------------------
  asbg_pkg::cfg_t shadow_cfg = '{asbg_pkg::RST_DEFAULT_COUNT, asbg_pkg::RST_MIN_COUNT,
                                 asbg_pkg::RST_MAX_COUNT, asbg_pkg::RST_WINDOW_LENGTH,
                                 asbg_pkg::RST_TARGET_TICKS, asbg_pkg::RST_MARGIN_Q8};

  logic [FRAC_SHIFT+asbg_pkg::DUR_W-1:0] hist_ring [RING_DEPTH];
  int unsigned                           hist_len  = 0;
  int unsigned                           hist_head = 0;   // index of the oldest entry
  logic [63:0]                           hist_sum  = '0;
  logic [asbg_pkg::MISS_W-1:0]           miss_run  = '0;

  // expected results, one per accepted report, oldest at pend_rd
  budget_rsp_t pending_budgets [PEND_DEPTH];
  int unsigned pend_wr     = 0;
  int unsigned pend_rd     = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // Works out the result of one report and advances the shadow state.
  function automatic budget_rsp_t predict_budget(input logic [asbg_pkg::DUR_W-1:0] dur,
                                                 input logic [asbg_pkg::SMP_W-1:0] cnt);
    budget_rsp_t                           r;
    logic [FRAC_SHIFT+asbg_pkg::DUR_W-1:0] per_sample;
    logic [63:0]                           avg;
    logic [63:0]                           quot;
    int unsigned                           win;
    int unsigned                           slot;
    // guard path: nothing moves, fallback shows the streak as it stands
    if (dur == '0 || cnt == '0) begin
      r.next_count   = shadow_cfg.default_count;
      r.used_default = 1'b1;
      r.fallback     = (miss_run >= asbg_pkg::MISS_FALLBACK);
      return r;
    end
    per_sample = {dur, {FRAC_SHIFT{1'b0}}} / cnt;

    win = shadow_cfg.window_length;
    if (win == 0) win = 1;
    if (win > RING_DEPTH) win = RING_DEPTH;

    // at most one eviction per push, so a history above a shrunk window keeps its length
    if (hist_len >= win) begin
      hist_sum  = hist_sum - hist_ring[hist_head];
      hist_head = (hist_head + 1) % RING_DEPTH;
      hist_len--;
    end
    slot            = (hist_head + hist_len) % RING_DEPTH;
    hist_ring[slot] = per_sample;
    hist_sum        = hist_sum + per_sample;
    hist_len++;

    if (dur > shadow_cfg.target_ticks) begin
      if (miss_run != asbg_pkg::MISS_MAX) miss_run++;
    end else begin
      miss_run = '0;
    end
    r.fallback = (miss_run >= asbg_pkg::MISS_FALLBACK);

    avg = hist_sum / hist_len;
    if (avg == '0) begin
      r.next_count   = shadow_cfg.default_count;
      r.used_default = 1'b1;
      return r;
    end

    // budget in Q34.8 (target ticks times the Q2.8 margin), scaled up to the per-sample time's fraction
    quot = (64'(shadow_cfg.target_ticks) * 64'(shadow_cfg.margin_q8)) << (FRAC_SHIFT - 8);
    quot = quot / avg;
    // lower bound first, upper last, so a crossed pair leaves max_count in charge
    if (quot < 64'(shadow_cfg.min_count)) quot = 64'(shadow_cfg.min_count);
    if (quot > 64'(shadow_cfg.max_count)) quot = 64'(shadow_cfg.max_count);
    r.next_count   = quot[asbg_pkg::COUNT_W-1:0];
    r.used_default = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Typed expectations are the ones visible without arithmetic;
  // the rest go through the predictor. Reset registers: window 8, target 20000.
  // ---------------------------------------------------------------------------
  report_row_t directed_rows [24] = '{
    // guard path straight after reset
    '{32'd0,          16'd0,      1'b1, '{asbg_pkg::RST_DEFAULT_COUNT, 1'b1, 1'b0}},
    '{32'd0,          16'd1234,   1'b1, '{asbg_pkg::RST_DEFAULT_COUNT, 1'b1, 1'b0}},
    '{32'd12345,      16'd0,      1'b1, '{asbg_pkg::RST_DEFAULT_COUNT, 1'b1, 1'b0}},
    // smallest per-sample time: quotient far above range, clamps to max
    '{32'd1,          16'hFFFF,   1'b1, '{asbg_pkg::RST_MAX_COUNT,     1'b0, 1'b0}},
    // longest durations: average huge, quotient zero, clamps to min; two misses
    '{32'hFFFF_FFFF,  16'd1,      1'b1, '{asbg_pkg::RST_MIN_COUNT,     1'b0, 1'b0}},
    '{32'hFFFF_FFFF,  16'hFFFF,   1'b1, '{asbg_pkg::RST_MIN_COUNT,     1'b0, 1'b1}},
    // guard path while in fallback
    '{32'd0,          16'hFFFF,   1'b1, '{asbg_pkg::RST_DEFAULT_COUNT, 1'b1, 1'b1}},
    // deadline boundary: equal is a hit, one above is a miss
    '{32'd20000,      16'd100,    1'b0, '0},
    '{32'd20001,      16'd100,    1'b0, '0},
    '{32'd20001,      16'd100,    1'b0, '0},
    '{32'd20000,      16'd100,    1'b0, '0},
    '{32'h8000_0000,  16'h8000,   1'b0, '0},
    '{32'h7FFF_FFFF,  16'h7FFF,   1'b0, '0},
    '{32'h5555_5555,  16'hAAAA,   1'b0, '0},
    '{32'hAAAA_AAAA,  16'h5555,   1'b0, '0},
    '{32'd1,          16'd1,      1'b0, '0},
    // ordinary loop reports: fill the window and evict the extremes
    '{32'd18000,      16'd900,    1'b0, '0},
    '{32'd21000,      16'd1000,   1'b0, '0},
    '{32'd19500,      16'd1100,   1'b0, '0},
    '{32'd25000,      16'd1200,   1'b0, '0},
    '{32'd26000,      16'd1200,   1'b0, '0},
    '{32'd15000,      16'd800,    1'b0, '0},
    '{32'd20000,      16'd1024,   1'b0, '0},
    '{32'd40000,      16'd4000,   1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  int unsigned tx_burst_left = 0;
  int unsigned hold_requests = 0;   // bumped by the sender, served by the receiver

  // Offers one report and waits for its transaction; valid stays up into the
  // next report unless the burst ends here.
  task automatic send_report(input logic [asbg_pkg::DUR_W-1:0] dur,
                             input logic [asbg_pkg::SMP_W-1:0] cnt,
                             input bit typed, input budget_rsp_t want);
    budget_rsp_t predicted;
    int unsigned gap;
    req_if.valid          <= 1'b1;
    req_if.duration_ticks <= dur;
    req_if.samples_used   <= cnt;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = predict_budget(dur, cnt);
    pending_budgets[pend_wr % PEND_DEPTH] = typed ? want : predicted;
    pend_wr++;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
    end else begin
      tx_burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      // long gaps spread the next offer across the whole report latency
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 170) : $urandom_range(1, 4);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every outstanding result has arrived.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register, then the bus goes idle.
  task automatic write_register(input logic [2:0] idx,
                                input logic [asbg_pkg::APB_DW-1:0] data);
    logic [asbg_pkg::APB_DW-1:0] want;
    want = '0;
    case (idx)
      asbg_pkg::REG_DEFAULT_COUNT: begin
        shadow_cfg.default_count = data[asbg_pkg::COUNT_W-1:0];
        want = asbg_pkg::APB_DW'(shadow_cfg.default_count);
      end
      asbg_pkg::REG_MIN_COUNT: begin
        shadow_cfg.min_count = data[asbg_pkg::COUNT_W-1:0];
        want = asbg_pkg::APB_DW'(shadow_cfg.min_count);
      end
      asbg_pkg::REG_MAX_COUNT: begin
        shadow_cfg.max_count = data[asbg_pkg::COUNT_W-1:0];
        want = asbg_pkg::APB_DW'(shadow_cfg.max_count);
      end
      asbg_pkg::REG_WINDOW_LENGTH: begin
        shadow_cfg.window_length = data[asbg_pkg::WLEN_W-1:0];
        want = asbg_pkg::APB_DW'(shadow_cfg.window_length);
      end
      asbg_pkg::REG_TARGET_TICKS: begin
        shadow_cfg.target_ticks = data[asbg_pkg::TGT_W-1:0];
        want = asbg_pkg::APB_DW'(shadow_cfg.target_ticks);
      end
      asbg_pkg::REG_MARGIN_Q8: begin
        shadow_cfg.margin_q8 = data[asbg_pkg::MRG_W-1:0];
        want = asbg_pkg::APB_DW'(shadow_cfg.margin_q8);
      end
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // straight into the read setup phase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d read back expected %h actual %h", $time, idx, want, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input asbg_pkg::cfg_t c);
    write_register(asbg_pkg::REG_DEFAULT_COUNT, asbg_pkg::APB_DW'(c.default_count));
    write_register(asbg_pkg::REG_MIN_COUNT,     asbg_pkg::APB_DW'(c.min_count));
    write_register(asbg_pkg::REG_MAX_COUNT,     asbg_pkg::APB_DW'(c.max_count));
    write_register(asbg_pkg::REG_WINDOW_LENGTH, asbg_pkg::APB_DW'(c.window_length));
    write_register(asbg_pkg::REG_TARGET_TICKS,  asbg_pkg::APB_DW'(c.target_ticks));
    write_register(asbg_pkg::REG_MARGIN_Q8,     asbg_pkg::APB_DW'(c.margin_q8));
  endtask

  function automatic asbg_pkg::cfg_t random_config();
    asbg_pkg::cfg_t c;
    c.default_count = asbg_pkg::COUNT_W'($urandom());
    c.min_count     = asbg_pkg::COUNT_W'($urandom_range(0, 300));
    c.max_count     = asbg_pkg::COUNT_W'($urandom_range(c.min_count, 65535));
    // mostly a legal window, now and then the out-of-range encodings
    c.window_length = ($urandom_range(0, 3) == 0) ? asbg_pkg::WLEN_W'($urandom_range(0, 31))
                                                  : asbg_pkg::WLEN_W'($urandom_range(1, 16));
    c.target_ticks  = ($urandom_range(0, 1) == 0) ? asbg_pkg::TGT_W'($urandom_range(100, 100000))
                                                  : asbg_pkg::TGT_W'($urandom());
    c.margin_q8     = asbg_pkg::MRG_W'($urandom_range(0, 1023));
    return c;
  endfunction

  // Mostly loop reports around the deadline, with guard reports and raw noise.
  task automatic pick_report(output logic [asbg_pkg::DUR_W-1:0] dur,
                             output logic [asbg_pkg::SMP_W-1:0] cnt);
    logic [63:0] d;
    int unsigned mode;
    mode = $urandom_range(0, 19);
    cnt  = ($urandom_range(0, 3) == 0) ? asbg_pkg::SMP_W'($urandom())
                                       : asbg_pkg::SMP_W'($urandom_range(1, 4096));
    if (cnt == '0) cnt = 1;
    d = 64'd1;
    case (mode)
      0:       d = 64'd0;
      1:       cnt = '0;
      2, 3: begin
        d   = 64'($urandom());
        cnt = asbg_pkg::SMP_W'($urandom());
      end
      4, 5, 6: d = 64'(shadow_cfg.target_ticks) + $urandom_range(0, 2) - 1;
      default: d = 64'(shadow_cfg.target_ticks) * $urandom_range(1, 64) / 16;
    endcase
    if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
    dur = d[asbg_pkg::DUR_W-1:0];
    if (mode == 1 && dur == '0) dur = asbg_pkg::DUR_W'($urandom());
    if (mode > 3 && dur == '0) dur = 1;
    if (mode == 0) cnt = asbg_pkg::SMP_W'($urandom());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern in segments of varying density, plus the long hold
  // ---------------------------------------------------------------------------
  int unsigned rx_holds_done = 0;
  int unsigned rx_hold_left  = 0;
  int unsigned rx_seg_left   = 0;
  int unsigned rx_ready_pct  = 100;

  always @(posedge clk_i) begin
    if (hold_requests != rx_holds_done) begin
      rx_holds_done++;
      rx_hold_left = LONG_HOLD;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      if (rx_seg_left == 0) begin
        rx_seg_left = $urandom_range(1, 60);
        case ($urandom_range(0, 3))
          0:       rx_ready_pct = 100;
          1:       rx_ready_pct = 70;
          2:       rx_ready_pct = 30;
          default: rx_ready_pct = 5;
        endcase
      end
      rx_seg_left--;
      rsp_if.ready <= ($urandom_range(1, 100) <= rx_ready_pct);
    end
  end

  // Result checker: every result transaction against the oldest expectation
  always @(posedge clk_i) begin
    budget_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pend_wr == pend_rd) begin
        $display("%0t: result with none outstanding: next_count %0d used_default %0b fallback %0b",
                 $time, rsp_if.next_count, rsp_if.used_default, rsp_if.fallback);
        fail_count++;
      end else begin
        want = pending_budgets[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (rsp_if.next_count !== want.next_count) begin
          $display("%0t: next_count expected %0d actual %0d",
                   $time, want.next_count, rsp_if.next_count);
          fail_count++;
        end
        if (rsp_if.used_default !== want.used_default) begin
          $display("%0t: used_default expected %0b actual %0b",
                   $time, want.used_default, rsp_if.used_default);
          fail_count++;
        end
        if (rsp_if.fallback !== want.fallback) begin
          $display("%0t: fallback expected %0b actual %0b",
                   $time, want.fallback, rsp_if.fallback);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase plan: extremes first, then random settings
  // ---------------------------------------------------------------------------
  asbg_pkg::cfg_t phase_cfg [N_PHASES];
  int unsigned    phase_len [N_PHASES];

  initial begin
    logic [asbg_pkg::DUR_W-1:0] dur;
    logic [asbg_pkg::SMP_W-1:0] cnt;

    req_if.valid          = 1'b0;
    req_if.duration_ticks = '0;
    req_if.samples_used   = '0;
    rsp_if.ready          = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    rst_ni                = 1'b0;

    // phase 0 keeps the reset registers
    phase_cfg[0] = shadow_cfg;
    phase_len[0] = 80;
    // widest everything: quotient well past 16 bits with max at the top of range
    phase_cfg[1] = '{16'hFFFF, 16'd0, 16'hFFFF, 5'd16, 32'hFFFF_FFFF, 10'd1023};
    phase_len[1] = 100;
    // zero deadline: every measured report misses, long enough to saturate the
    // streak; window 0 acts as one; bounds crossed so max wins; zero margin
    phase_cfg[2] = '{16'd0, 16'hFFFF, 16'h1234, 5'd0, 32'd0, 10'd0};
    phase_len[2] = 340;
    // window encoding above the ring depth
    phase_cfg[3] = '{16'h1234, 16'd0, 16'hFFFF, 5'd31, 32'd5000, 10'd512};
    phase_len[3] = 100;
    // window shrinks from a full ring down to two
    phase_cfg[4] = '{16'h00FF, 16'd100, 16'd2000, 5'd2, 32'd5000, 10'd128};
    phase_len[4] = 100;
    for (int p = 5; p < N_PHASES; p++) begin
      phase_cfg[p] = random_config();
      phase_len[p] = 76;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_report(directed_rows[i].dur, directed_rows[i].cnt,
                  directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        apply_config(phase_cfg[p]);
      end
      for (int i = 0; i < phase_len[p]; i++) begin
        // receiver goes quiet while reports keep coming, so the input backs up
        if (p == 0 && i == 5) hold_requests <= hold_requests + 1;
        // and once per phase the sender waits for the block to empty
        if (i == phase_len[p] / 2) drain_results();
        pick_report(dur, cnt);
        send_report(dur, cnt, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
src/asbg_pkg.sv
src/asbg_if.sv
src/asbg_ram.sv
src/asbg_div.sv
src/asbg_dp.sv
src/asbg_ctrl.sv
src/adaptive_sample_budget_governor_unit.sv
tb/adaptive_sample_budget_governor_unit_tb.sv
